### src/bpp_pkg.sv
// Shared types, constants and fixed-point helpers for the particle pusher.
// Depends on nothing; every other file of the block but the port checker imports it.
package bpp_pkg;

  localparam int FracBits  = 16;
  localparam int WordBits  = 32;
  localparam int PosBits   = 31;
  localparam int QuotBits  = FracBits + 2;   // s = 2^(2F+1)/den <= 2^(F+1)
  localparam int DenBits   = WordBits + 1;
  localparam int RemBits   = DenBits + 1;
  localparam int WrapBits  = PosBits + 1;
  localparam int DivLead   = 2 * FracBits + 1 - QuotBits;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [PosBits-1:0]  pos_t;
  typedef word_t [2:0]         vec3_t;
  typedef pos_t  [2:0]         pvec3_t;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_TIME_STEP = 3'd0,
    CFG_QM        = 3'd1,
    CFG_BOX_X     = 3'd2,
    CFG_BOX_Y     = 3'd3,
    CFG_BOX_Z     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    pos_t   dt;
    word_t  qm;
    pvec3_t box;
  } cfg_t;

  typedef struct packed {
    pvec3_t pos;
    vec3_t  vel;
    vec3_t  ef;
    vec3_t  bf;
  } in_t;

  // front half to divider
  typedef struct packed {
    pvec3_t             pos;
    vec3_t              vm;
    vec3_t              kick;
    vec3_t              c;
    logic [DenBits-1:0] den;
    logic               sat;
  } mid_t;

  // divider to back half
  typedef struct packed {
    mid_t                m;
    logic [QuotBits-1:0] s;
  } divq_t;

  // back half to wrap unit
  typedef struct packed {
    vec3_t p;
    vec3_t vn;
    logic  sat;
  } wrp_t;

  typedef struct packed {
    pvec3_t pos;
    vec3_t  vel;
    logic   sat;
  } res_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } fx_t;

  // Product shifted down by the fraction, floor rounding, saturated
  function automatic fx_t fx_mul(input word_t a, input word_t b);
    logic signed [2*WordBits-1:0] prod;
    fx_t r;
    prod = $signed(a) * $signed(b);
    if ((&prod[2*WordBits-1:WordBits+FracBits-1]) ||
        !(|prod[2*WordBits-1:WordBits+FracBits-1])) begin
      r.sat = 1'b0;
      r.val = prod[WordBits+FracBits-1:FracBits];
    end else begin
      r.sat = 1'b1;
      r.val = prod[2*WordBits-1] ? WordMin : WordMax;
    end
    return r;
  endfunction

  function automatic fx_t fx_add(input word_t a, input word_t b);
    logic [WordBits:0] s;
    fx_t r;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    r.sat = s[WordBits] != s[WordBits-1];
    r.val = r.sat ? (s[WordBits] ? WordMin : WordMax) : s[WordBits-1:0];
    return r;
  endfunction

  function automatic fx_t fx_sub(input word_t a, input word_t b);
    logic [WordBits:0] s;
    fx_t r;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    r.sat = s[WordBits] != s[WordBits-1];
    r.val = r.sat ? (s[WordBits] ? WordMin : WordMax) : s[WordBits-1:0];
    return r;
  endfunction

endpackage

### src/boris_particle_push_core.sv
// Boris particle pusher: one particle per clock unless held, in a fixed pipeline.
// Top level: configuration registers, pipeline halves, output buffer; uses bpp_pkg.
//
// The core takes one particle word per cycle unless held and returns its
// pushed word through 7 front stages, 18 divider stages for s, 4 back stages,
// 31 wrap stages and 2 output stages, in input order. The latency is set by the
// one-bit-per-stage divider for s and the one-bit-per-stage floor modulo of the
// position by the box length. A two-word output buffer lets a new particle enter
// while one finished word waits; the pipeline holds only when both slots are full
// and the sink is not ready. The user must write registers through cfg_we_i /
// cfg_idx_i / cfg_data_i only while no particle is in flight; not enforced here.
module boris_particle_push_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
  // bfield_x, bfield_y, bfield_z, zero pad
  input  logic [383:0] s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, zero pad
  output logic [191:0] m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser
);
  import bpp_pkg::*;

  localparam int PosW3 = 3 * PosBits;

  cfg_t  cfg_q;
  in_t   in_w;
  mid_t  mid_w;
  divq_t div_w;
  wrp_t  wrp_w;
  res_t  res_w;
  logic  mid_vld;
  logic  div_vld;
  logic  wrp_vld;
  logic  res_vld;
  logic  en;

  res_t       buf0_q;
  res_t       buf0_d;
  res_t       buf1_q;
  res_t       buf1_d;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       push;
  logic       pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dt     <= '0;
      cfg_q.qm     <= word_t'(65536);
      cfg_q.box[0] <= pos_t'(655360);
      cfg_q.box[1] <= pos_t'(655360);
      cfg_q.box[2] <= pos_t'(655360);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_STEP: cfg_q.dt     <= cfg_data_i[PosBits-1:0];
        CFG_QM:        cfg_q.qm     <= cfg_data_i;
        CFG_BOX_X:     cfg_q.box[0] <= cfg_data_i[PosBits-1:0];
        CFG_BOX_Y:     cfg_q.box[1] <= cfg_data_i[PosBits-1:0];
        CFG_BOX_Z:     cfg_q.box[2] <= cfg_data_i[PosBits-1:0];
        default:       ;
      endcase
    end
  end

  // unpack the input word
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_w.pos[i] = s_axis_tdata[i*PosBits +: PosBits];
      in_w.vel[i] = s_axis_tdata[PosW3 + i*WordBits +: WordBits];
      in_w.ef[i]  = s_axis_tdata[PosW3 + (3+i)*WordBits +: WordBits];
      in_w.bf[i]  = s_axis_tdata[PosW3 + (6+i)*WordBits +: WordBits];
    end
  end

  // the whole pipeline advances unless both buffer slots would overflow
  assign en            = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;

  bpp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .vld_i  (s_axis_tvalid),
    .in_i   (in_w),
    .vld_o  (mid_vld),
    .mid_o  (mid_w)
  );

  bpp_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mid_vld),
    .mid_i  (mid_w),
    .vld_o  (div_vld),
    .div_o  (div_w)
  );

  bpp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .vld_i  (div_vld),
    .div_i  (div_w),
    .vld_o  (wrp_vld),
    .wrp_o  (wrp_w)
  );

  bpp_wrap u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .vld_i  (wrp_vld),
    .wrp_i  (wrp_w),
    .vld_o  (res_vld),
    .res_o  (res_w)
  );

  // two-slot output buffer, slot 0 is the head
  assign push = en && res_vld;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    buf0_d = buf0_q;
    buf1_d = buf1_q;
    cnt_d  = cnt_q;
    case (cnt_q)
      2'd0: begin
        if (push) begin
          buf0_d = res_w;
          cnt_d  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          buf0_d = res_w;
        end else if (push) begin
          buf1_d = res_w;
          cnt_d  = 2'd2;
        end else if (pop) begin
          cnt_d  = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          buf0_d = buf1_q;
          if (push) begin
            buf1_d = res_w;
          end else begin
            cnt_d = 2'd1;
          end
        end
      end
      default: cnt_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

  // pack the output word
  assign m_axis_tvalid = cnt_q != 2'd0;
  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[i*PosBits +: PosBits]           = buf0_q.pos[i];
      m_axis_tdata[PosW3 + i*WordBits +: WordBits] = buf0_q.vel[i];
    end
  end
  assign m_axis_tuser = buf0_q.sat;

endmodule

### src/bpp_front.sv
// Front half of the push: half kick, t vector, |t|^2, first rotation, v' x t.
// Seven register stages; uses bpp_pkg.
module bpp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bpp_pkg::cfg_t cfg_i,
  input  logic          vld_i,
  input  bpp_pkg::in_t  in_i,
  output logic          vld_o,
  output bpp_pkg::mid_t mid_o
);
  import bpp_pkg::*;

  localparam int Stages = 7;

  typedef struct packed {
    pvec3_t             pos;
    vec3_t              vel;
    vec3_t              ef;
    vec3_t              bf;
    vec3_t              kick;
    vec3_t              t;
    vec3_t              vm;
    vec3_t              tsq;
    vec3_t              p1;
    vec3_t              p2;
    vec3_t              vp;
    vec3_t              c;
    word_t              qdt;
    logic [DenBits-1:0] den;
    logic               sat;
  } fr_t;

  fr_t  st_d [1:Stages];
  fr_t  st_q [1:Stages];
  logic [Stages:1] vld_q;

  // per-stage arithmetic
  always_comb begin
    fx_t a;
    fx_t b;
    fx_t c;
    word_t h;
    logic [WordBits+1:0] tsum;
    word_t tmag;
    int y;
    int z;

    // stage 1: q/m * dt
    st_d[1]     = '0;
    st_d[1].pos = in_i.pos;
    st_d[1].vel = in_i.vel;
    st_d[1].ef  = in_i.ef;
    st_d[1].bf  = in_i.bf;
    a = fx_mul(cfg_i.qm, {1'b0, cfg_i.dt});
    st_d[1].qdt = a.val;
    st_d[1].sat = a.sat;

    // stage 2: halve, kick = h*E, t = h*B
    st_d[2] = st_q[1];
    h = {st_q[1].qdt[WordBits-1], st_q[1].qdt[WordBits-1:1]};
    for (int i = 0; i < 3; i++) begin
      a = fx_mul(h, st_q[1].ef[i]);
      b = fx_mul(h, st_q[1].bf[i]);
      st_d[2].kick[i] = a.val;
      st_d[2].t[i]    = b.val;
      st_d[2].sat     = st_d[2].sat | a.sat | b.sat;
    end

    // stage 3: v- and t squares
    st_d[3] = st_q[2];
    for (int i = 0; i < 3; i++) begin
      a = fx_add(st_q[2].vel[i], st_q[2].kick[i]);
      b = fx_mul(st_q[2].t[i], st_q[2].t[i]);
      st_d[3].vm[i]  = a.val;
      st_d[3].tsq[i] = b.val;
      st_d[3].sat    = st_d[3].sat | a.sat | b.sat;
    end

    // stage 4: |t|^2 and denominator, v- x t products
    st_d[4] = st_q[3];
    tsum = {2'b00, st_q[3].tsq[0]} + {2'b00, st_q[3].tsq[1]} + {2'b00, st_q[3].tsq[2]};
    if (tsum > {2'b00, WordMax}) begin
      tmag = WordMax;
      st_d[4].sat = 1'b1;
    end else begin
      tmag = tsum[WordBits-1:0];
    end
    st_d[4].den = {1'b0, tmag} + (DenBits'(1) << FracBits);
    for (int i = 0; i < 3; i++) begin
      y = (i == 2) ? 0 : i + 1;
      z = (i == 0) ? 2 : i - 1;
      a = fx_mul(st_q[3].vm[y], st_q[3].t[z]);
      b = fx_mul(st_q[3].vm[z], st_q[3].t[y]);
      st_d[4].p1[i] = a.val;
      st_d[4].p2[i] = b.val;
      st_d[4].sat   = st_d[4].sat | a.sat | b.sat;
    end

    // stage 5: v' = v- + v- x t
    st_d[5] = st_q[4];
    for (int i = 0; i < 3; i++) begin
      a = fx_sub(st_q[4].p1[i], st_q[4].p2[i]);
      b = fx_add(st_q[4].vm[i], a.val);
      st_d[5].vp[i] = b.val;
      st_d[5].sat   = st_d[5].sat | a.sat | b.sat;
    end

    // stage 6: v' x t products
    st_d[6] = st_q[5];
    for (int i = 0; i < 3; i++) begin
      y = (i == 2) ? 0 : i + 1;
      z = (i == 0) ? 2 : i - 1;
      a = fx_mul(st_q[5].vp[y], st_q[5].t[z]);
      b = fx_mul(st_q[5].vp[z], st_q[5].t[y]);
      st_d[6].p1[i] = a.val;
      st_d[6].p2[i] = b.val;
      st_d[6].sat   = st_d[6].sat | a.sat | b.sat;
    end

    // stage 7: cross product difference
    st_d[7] = st_q[6];
    for (int i = 0; i < 3; i++) begin
      c = fx_sub(st_q[6].p1[i], st_q[6].p2[i]);
      st_d[7].c[i] = c.val;
      st_d[7].sat  = st_d[7].sat | c.sat;
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-1:1], vld_i};
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o      = vld_q[Stages];
  assign mid_o.pos  = st_q[Stages].pos;
  assign mid_o.vm   = st_q[Stages].vm;
  assign mid_o.kick = st_q[Stages].kick;
  assign mid_o.c    = st_q[Stages].c;
  assign mid_o.den  = st_q[Stages].den;
  assign mid_o.sat  = st_q[Stages].sat;

endmodule

### src/bpp_sdiv.sv
// Pipelined restoring divider for s = 2^(2F+1) / den, one quotient bit a stage.
// Carries the rest of the item alongside; uses bpp_pkg.
module bpp_sdiv (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  bpp_pkg::mid_t  mid_i,
  output logic           vld_o,
  output bpp_pkg::divq_t div_o
);
  import bpp_pkg::*;

  typedef struct packed {
    mid_t                m;
    logic [RemBits-1:0]  rem;
    logic [QuotBits-1:0] q;
  } dv_t;

  dv_t  st_d [1:QuotBits];
  dv_t  st_q [1:QuotBits];
  logic [QuotBits:1] vld_q;

  // one quotient bit per stage, most significant first
  always_comb begin
    dv_t cur;
    logic [RemBits-1:0] sh;
    for (int k = 1; k <= QuotBits; k++) begin
      if (k == 1) begin
        cur.m   = mid_i;
        cur.rem = RemBits'(1) << DivLead;
        cur.q   = '0;
      end else begin
        cur = st_q[k-1];
      end
      sh = {cur.rem[RemBits-2:0], 1'b0};
      st_d[k] = cur;
      if (sh >= {1'b0, cur.m.den}) begin
        st_d[k].rem = sh - {1'b0, cur.m.den};
        st_d[k].q[QuotBits-k] = 1'b1;
      end else begin
        st_d[k].rem = sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotBits-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o   = vld_q[QuotBits];
  assign div_o.m = st_q[QuotBits].m;
  assign div_o.s = st_q[QuotBits].q;

endmodule

### src/bpp_back.sv
// Back half of the push: scaled rotation, second half kick, position advance.
// Four register stages; uses bpp_pkg.
module bpp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  bpp_pkg::cfg_t  cfg_i,
  input  logic           vld_i,
  input  bpp_pkg::divq_t div_i,
  output logic           vld_o,
  output bpp_pkg::wrp_t  wrp_o
);
  import bpp_pkg::*;

  localparam int Stages = 4;

  typedef struct packed {
    pvec3_t pos;
    vec3_t  vm;
    vec3_t  kick;
    vec3_t  c;
    vec3_t  sc;
    vec3_t  vn;
    vec3_t  pd;
    vec3_t  p;
    word_t  s;
    logic   sat;
  } bk_t;

  bk_t  st_d [1:Stages];
  bk_t  st_q [1:Stages];
  logic [Stages:1] vld_q;

  always_comb begin
    fx_t a;
    fx_t b;

    // stage 1: s * (v' x t)
    st_d[1]      = '0;
    st_d[1].pos  = div_i.m.pos;
    st_d[1].vm   = div_i.m.vm;
    st_d[1].kick = div_i.m.kick;
    st_d[1].c    = div_i.m.c;
    st_d[1].s    = {{(WordBits-QuotBits){1'b0}}, div_i.s};
    st_d[1].sat  = div_i.m.sat;
    for (int i = 0; i < 3; i++) begin
      a = fx_mul(st_d[1].s, div_i.m.c[i]);
      st_d[1].sc[i] = a.val;
      st_d[1].sat   = st_d[1].sat | a.sat;
    end

    // stage 2: v+ and second half kick
    st_d[2] = st_q[1];
    for (int i = 0; i < 3; i++) begin
      a = fx_add(st_q[1].vm[i], st_q[1].sc[i]);
      b = fx_add(a.val, st_q[1].kick[i]);
      st_d[2].vn[i] = b.val;
      st_d[2].sat   = st_d[2].sat | a.sat | b.sat;
    end

    // stage 3: displacement v * dt
    st_d[3] = st_q[2];
    for (int i = 0; i < 3; i++) begin
      a = fx_mul(st_q[2].vn[i], {1'b0, cfg_i.dt});
      st_d[3].pd[i] = a.val;
      st_d[3].sat   = st_d[3].sat | a.sat;
    end

    // stage 4: new unwrapped position
    st_d[4] = st_q[3];
    for (int i = 0; i < 3; i++) begin
      a = fx_add({1'b0, st_q[3].pos[i]}, st_q[3].pd[i]);
      st_d[4].p[i] = a.val;
      st_d[4].sat  = st_d[4].sat | a.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-1:1], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o     = vld_q[Stages];
  assign wrp_o.p   = st_q[Stages].p;
  assign wrp_o.vn  = st_q[Stages].vn;
  assign wrp_o.sat = st_q[Stages].sat;

endmodule

### src/bpp_wrap.sv
// Periodic wrap: floor modulo of each position by its box length,
// one remainder bit a stage on all three axes; uses bpp_pkg.
module bpp_wrap (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  bpp_pkg::cfg_t cfg_i,
  input  logic          vld_i,
  input  bpp_pkg::wrp_t wrp_i,
  output logic          vld_o,
  output bpp_pkg::res_t res_o
);
  import bpp_pkg::*;

  typedef struct packed {
    vec3_t                     vn;
    logic                      sat;
    logic [2:0]                neg;
    pvec3_t                    m;
    logic [2:0][WrapBits-1:0]  rem;
  } wr_t;

  wr_t  st_d [1:PosBits];
  wr_t  st_q [1:PosBits];
  logic [PosBits:1] vld_q;
  res_t res_d;
  res_t res_q;
  logic res_vld_q;

  // restoring remainder on the magnitude; negatives use ~p and reflect at the end
  always_comb begin
    wr_t cur;
    logic [WrapBits-1:0] sh;
    for (int k = 1; k <= PosBits; k++) begin
      if (k == 1) begin
        cur.vn  = wrp_i.vn;
        cur.sat = wrp_i.sat;
        cur.rem = '0;
        for (int a = 0; a < 3; a++) begin
          cur.neg[a] = wrp_i.p[a][WordBits-1];
          cur.m[a]   = cur.neg[a] ? ~wrp_i.p[a][PosBits-1:0] : wrp_i.p[a][PosBits-1:0];
        end
      end else begin
        cur = st_q[k-1];
      end
      st_d[k] = cur;
      for (int a = 0; a < 3; a++) begin
        sh = {cur.rem[a][PosBits-1:0], cur.m[a][PosBits-k]};
        if (sh >= {1'b0, cfg_i.box[a]}) begin
          st_d[k].rem[a] = sh - {1'b0, cfg_i.box[a]};
        end else begin
          st_d[k].rem[a] = sh;
        end
      end
    end
  end

  // fold sign and zero length into the final position
  always_comb begin
    res_d.vel = st_q[PosBits].vn;
    res_d.sat = st_q[PosBits].sat;
    for (int a = 0; a < 3; a++) begin
      if (cfg_i.box[a] == '0) begin
        res_d.pos[a] = '0;
      end else if (st_q[PosBits].neg[a]) begin
        res_d.pos[a] = cfg_i.box[a] - pos_t'(1) - st_q[PosBits].rem[a][PosBits-1:0];
      end else begin
        res_d.pos[a] = st_q[PosBits].rem[a][PosBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[PosBits-1:1], vld_i};
      res_vld_q <= vld_q[PosBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      res_q <= res_d;
    end
  end

  assign vld_o = res_vld_q;
  assign res_o = res_q;

endmodule

### src/bpp_checker.sv
// Port-level checks for the particle pusher core, bound to its top level.
// Depends only on the top level's ports.
module bpp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_we_i,
  input logic [2:0]   cfg_idx_i,
  input logic [31:0]  cfg_data_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [383:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // input may only be refused while a word waits at the output
  a_back_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output back-pressure");

  // pad bits of the output word stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[191:189] == 3'b000)
    else $error("output pad bits set");

endmodule

bind boris_particle_push_core bpp_checker u_bpp_checker (.*);

### dv/bpp_checker.sv
// Scoreboard for the particle pusher: mirrors the register writes, predicts each pushed word
// and compares it with the output stream. Uses bpp_pkg for the register index codes.
module bpp_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [383:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [191:0] m_data_i,
  input  logic [0:0]   m_user_i,
  output int           fail_count_o,
  output int           pending_o
);
  import bpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMax = 64'sd2147483647;
  localparam longint WMin = -64'sd2147483648;

  typedef struct packed {
    logic [2:0][30:0] pos;
    logic [2:0][31:0] vel;
    logic             sat;
  } push_t;

  push_t  pushed_q[$];
  logic [30:0] dt_r;
  logic [31:0] qm_r;
  logic [30:0] box_r [3];
  bit     ovf;
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = pushed_q.size();

  function automatic longint clampw(longint v);
    if (v > WMax) begin ovf = 1'b1; return WMax; end
    if (v < WMin) begin ovf = 1'b1; return WMin; end
    return v;
  endfunction

  // operands are always in word range, so the exact product fits in 64 bits
  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return clampw(p >>> 16);
  endfunction

  function automatic longint fadd(longint a, longint b);
    return clampw(a + b);
  endfunction

  function automatic longint fsub(longint a, longint b);
    return clampw(a - b);
  endfunction

  function automatic longint sfield(logic [383:0] d, int lsb);
    logic [31:0] w;
    w = d[lsb +: 32];
    return longint'($signed(w));
  endfunction

  function automatic push_t push_particle(logic [383:0] d);
    longint pos[3], v[3], e[3], b[3], kick[3], t[3], vm[3], vp[3], vn[3];
    longint dt, qdt, h, tmag, s, c, p, len, r;
    int y, z;
    push_t res;
    ovf  = 1'b0;
    dt   = longint'(dt_r);
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'(d[31*i +: 31]);
      v[i]   = sfield(d, 93 + 32*i);
      e[i]   = sfield(d, 189 + 32*i);
      b[i]   = sfield(d, 285 + 32*i);
    end
    qdt  = fmul(longint'($signed(qm_r)), dt);
    h    = qdt >>> 1;
    tmag = 0;
    for (int i = 0; i < 3; i++) begin
      kick[i] = fmul(h, e[i]);
      t[i]    = fmul(h, b[i]);
      vm[i]   = fadd(v[i], kick[i]);
      tmag    = fadd(tmag, fmul(t[i], t[i]));
    end
    s = (64'sd1 <<< 33) / (64'sd65536 + tmag);
    if (s > WMax) begin ovf = 1'b1; s = WMax; end
    // half rotation, then full rotation scaled by s
    for (int i = 0; i < 3; i++) begin
      y = (i + 1) % 3; z = (i + 2) % 3;
      vp[i] = fadd(vm[i], fsub(fmul(vm[y], t[z]), fmul(vm[z], t[y])));
    end
    for (int i = 0; i < 3; i++) begin
      y = (i + 1) % 3; z = (i + 2) % 3;
      c     = fsub(fmul(vp[y], t[z]), fmul(vp[z], t[y]));
      vn[i] = fadd(fadd(vm[i], fmul(s, c)), kick[i]);
    end
    // advance and wrap periodically
    for (int i = 0; i < 3; i++) begin
      p   = fadd(pos[i], fmul(vn[i], dt));
      len = longint'(box_r[i]);
      r   = 0;
      if (len > 0) begin
        r = p % len;
        if (r < 0) r += len;
      end
      res.pos[i] = r[30:0];
      res.vel[i] = vn[i][31:0];
    end
    res.sat = ovf;
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    push_t want;
    if (!rst_ni) begin
      dt_r  <= '0;
      qm_r  <= 32'd65536;
      box_r <= '{31'd655360, 31'd655360, 31'd655360};
      fails <= 0;
      pushed_q.delete();
    end else begin
      // mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TIME_STEP: dt_r     <= cfg_data_i[30:0];
          CFG_QM:        qm_r     <= cfg_data_i;
          CFG_BOX_X:     box_r[0] <= cfg_data_i[30:0];
          CFG_BOX_Y:     box_r[1] <= cfg_data_i[30:0];
          CFG_BOX_Z:     box_r[2] <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) pushed_q.insert(pushed_q.size(), push_particle(s_data_i));
      // compare each output word with the oldest prediction
      if (m_valid_i && m_ready_i) begin
        if (pushed_q.size() == 0) begin
          if (fails < 10) $display("checker: unexpected word %h", m_data_i);
          fails <= fails + 1;
        end else begin
          want = pushed_q.pop_front();
          if (m_data_i[92:0] !== want.pos || m_data_i[188:93] !== want.vel ||
              m_data_i[191:189] !== 3'b0 || m_user_i[0] !== want.sat) begin
            if (fails < 10)
              $display("checker: mismatch exp pos=%h vel=%h sat=%b got pos=%h vel=%h sat=%b",
                       want.pos, want.vel, want.sat, m_data_i[92:0], m_data_i[188:93],
                       m_user_i[0]);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
// Stimulus and verdict for the particle pusher: drives register phases and particle words
// with random gaps and sink stalls. Depends on bpp_pkg, boris_particle_push_core, bpp_scoreboard.
module tb_top;
  import bpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Limit = 600000;

  logic         clk_i, rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid, s_axis_tready;
  logic [383:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           fail_count, pending;
  int           cycles = 0;
  int           stall_mode;

  boris_particle_push_core u_top (.*);

  bpp_scoreboard u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_user_i(m_axis_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // sink stalls: mode 0 never stalls, 1 short random stalls, 2 mostly stalled, ready only occasionally
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 40) == 0);
    endcase
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [31:0] rnd_word(bit wide);
    logic [31:0] w;
    w = $urandom();
    if (!wide) w = {{12{w[19]}}, w[19:0]};
    return w;
  endfunction

  function automatic logic [383:0] pack_particle(logic [2:0][30:0] p, logic [2:0][31:0] v,
                                                 logic [2:0][31:0] e, logic [2:0][31:0] b);
    return {3'b0, b, e, v, p};
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold the sender until every pushed word is back
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic send_word(logic [383:0] d, bit gaps);
    bit acc;
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do begin
      @(negedge clk_i);
      acc = s_axis_tready;
      @(posedge clk_i);
    end while (!acc);
  endtask

  task automatic send_random(int n, logic [30:0] boxlen);
    logic [2:0][30:0] p;
    logic [2:0][31:0] v, e, b;
    bit wide;
    for (int k = 0; k < n; k++) begin
      wide = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < 3; i++) begin
        p[i] = (wide || boxlen == 0) ? 31'($urandom()) : 31'($urandom() % boxlen);
        v[i] = rnd_word(wide);
        e[i] = rnd_word(wide || $urandom_range(0, 9) == 0);
        b[i] = rnd_word(wide || $urandom_range(0, 9) == 0);
      end
      send_word(pack_particle(p, v, e, b), 1'b1);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic set_phase(logic [30:0] dt, logic [31:0] qm, logic [30:0] bx,
                           logic [30:0] by, logic [30:0] bz);
    cfg_write(CFG_TIME_STEP, {1'b0, dt});
    cfg_write(CFG_QM, qm);
    cfg_write(CFG_BOX_X, {1'b0, bx});
    cfg_write(CFG_BOX_Y, {1'b0, by});
    cfg_write(CFG_BOX_Z, {1'b0, bz});
  endtask

  initial begin
    logic [2:0][30:0] p;
    logic [2:0][31:0] v, e, b;
    logic [30:0] dts [6] = '{31'h0, 31'h7fffffff, 31'h8000, 31'h100, 31'h10000, 31'h4000};
    logic [31:0] qms [6] = '{32'h80000000, 32'h7fffffff, 32'h10000, 32'hffff0000,
                             32'h20000, 32'h1};
    logic [30:0] boxes [5] = '{31'h0, 31'h1, 31'h7fffffff, 31'ha0000, 31'h40000};
    logic [30:0] bx;
    rst_ni = 1'b0; stall_mode = 0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: dt 0.5, q/m 1.0, box 10.0
    set_phase(31'h8000, 32'h10000, 31'ha0000, 31'ha0000, 31'ha0000);
    stall_mode = 1;
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = 31'h50000; v[i] = 32'h10000; e[i] = 32'h0; b[i] = 32'h0;
      end
      case (k)
        0: begin p = '0; v = '0; end
        1: p = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff};    // far outside the box
        2: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        3: v = '{32'h80000000, 32'h80000000, 32'h80000000};
        4: e = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};    // large kick
        5: b = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};    // t squared saturates
        6: b = '{32'h80000000, 32'h80000000, 32'h80000000};
        7: begin p = '0; v = '{32'hfffe0000, 32'hfffe0000, 32'hfffe0000}; end  // wrap below 0
        8: begin p = '{31'h9ffff, 31'h9ffff, 31'h9ffff}; end   // wrap above L
        9: b = '{32'h0, 32'h0, 32'h20000};
        10: begin e = '{32'h30000, 32'hfffd0000, 32'h8000}; b = '{32'h10000, 32'h0, 32'h0}; end
        11: begin v = '{32'h7fffffff, 32'h80000000, 32'h0}; b = '{32'h0, 32'h0, 32'h7fffffff}; end
        12: begin
          v = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
          e = '{32'hffffffff, 32'h1, 32'h0};
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            p[i] = 31'($urandom()); v[i] = $urandom(); e[i] = $urandom(); b[i] = $urandom();
          end
        end
      endcase
      send_word(pack_particle(p, v, e, b), 1'b1);
    end
    s_axis_tvalid <= 1'b0;
    drain();

    // random phases over register settings, extremes among them
    for (int ph = 0; ph < 10; ph++) begin
      stall_mode = ph % 3;
      bx = boxes[$urandom_range(1, 4)];
      if (ph < 6) set_phase(dts[ph], qms[ph], boxes[ph % 5], bx, boxes[(ph + 2) % 5]);
      else set_phase(31'($urandom_range(0, 31'h20000)), $urandom(), bx, bx, bx);
      send_random(80, bx);
      drain();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

### boris_particle_push_core.f
src/bpp_pkg.sv
src/bpp_front.sv
src/bpp_sdiv.sv
src/bpp_back.sv
src/bpp_wrap.sv
src/boris_particle_push_core.sv
src/bpp_checker.sv
dv/bpp_checker.sv
dv/tb_top.sv
